>>> rtl/core/crlf_line_assembler_core_defines.svh
// Assertion macros shared by the line assembler checker.
`ifndef CRLF_LINE_ASSEMBLER_CORE_DEFINES_SVH
`define CRLF_LINE_ASSEMBLER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CLAL_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define CLAL_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/clal_pkg.sv
// Shared constants, types and codes for the CR LF line assembler.
package clal_pkg;

   localparam int LINE_BYTES     = 256;
   localparam int BYTE_W         = 8;
   localparam int BYTES_PER_WORD = 8;
   localparam int LANE_W         = $clog2(BYTES_PER_WORD);
   localparam int WORD_W         = BYTE_W * BYTES_PER_WORD;
   localparam int CNT_W          = 4;
   localparam int FILL_W         = $clog2(LINE_BYTES) + 1;
   localparam int ADDR_W         = $clog2(LINE_BYTES);
   localparam int WORDS          = LINE_BYTES / BYTES_PER_WORD;
   localparam int WORD_AW        = $clog2(WORDS);

   localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_READ = 2'd1,
      ST_OUT  = 2'd2
   } state_type;

   typedef enum logic [1:0] {
      MODE_NORMAL     = 2'd0,
      MODE_DISCARD    = 2'd1,
      MODE_DISCARD_CR = 2'd2
   } mode_type;

   // Byte write into one lane of one store word
   typedef struct packed {
      logic               en;
      logic [WORD_AW-1:0] word;
      logic [LANE_W-1:0]  lane;
      logic [BYTE_W-1:0]  data;
   } ram_wr_type;

   // Full-word read request
   typedef struct packed {
      logic               en;
      logic [WORD_AW-1:0] word;
   } ram_rd_type;

endpackage

>>> rtl/core/clal_req_if.sv
// Input channel: one received byte per transaction.
interface clal_req_if
   import clal_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> rtl/core/clal_rsp_if.sv
// Result channel: one packed line word per transaction.
interface clal_rsp_if
   import clal_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] line_bytes;
   logic [CNT_W-1:0]  byte_count;
   logic              last_word;

   modport source (output valid, output line_bytes, output byte_count, output last_word,
                   input ready);
   modport sink   (input valid, input line_bytes, input byte_count, input last_word,
                   output ready);
endinterface

>>> rtl/core/crlf_line_assembler_core.sv
// CR LF line assembler: takes one received byte per transaction on req_bus and
// gathers it in a 256-byte line store held as 32 words of eight byte lanes. A byte
// that causes no output leaves the core idle, so bytes may follow back to back.
// The byte that completes a line (LF after a stored CR, or any byte once the store
// is full behind a CR) starts a flush: each output word is first read from the
// store's single registered read port (ST_READ) and then presented on rsp_bus
// (ST_OUT) until the sink raises ready. An L-byte line gives max(1, ceil(L/8))
// words, up to 32, and no byte is accepted until its last word has been taken.
// Words carry up to eight bytes, first byte in the low lane, with unused lanes
// zero; an empty line gives one word with a count of zero. The store needs no
// clearing after reset.
module crlf_line_assembler_core
   import clal_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   clal_req_if.sink   req_bus,
   clal_rsp_if.source rsp_bus
);

   ram_wr_type        wr_req;
   ram_rd_type        rd_req;
   logic [WORD_W-1:0] rd_data;

   // Parser and flush sequencer
   clal_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .wr_req  (wr_req),
      .rd_req  (rd_req),
      .rd_data (rd_data)
   );

   // Line store
   clal_line_ram u_ram (
      .clock   (clock),
      .wr_req  (wr_req),
      .rd_req  (rd_req),
      .rd_data (rd_data)
   );

endmodule

>>> rtl/core/clal_line_ram.sv
// Line store: byte-lane writes, full-word registered reads.
module clal_line_ram
   import clal_pkg::*;
(
   input  logic              clock,
   input  ram_wr_type        wr_req,
   input  ram_rd_type        rd_req,
   output logic [WORD_W-1:0] rd_data
);

   logic [BYTE_W-1:0] line_mem_ff [WORDS][BYTES_PER_WORD];
   logic [WORD_W-1:0] rd_data_ff;

   // Single byte write port
   always_ff @(posedge clock) begin
      if (wr_req.en) begin
         line_mem_ff[wr_req.word][wr_req.lane] <= wr_req.data;
      end
   end

   // Word read, held until the next read
   always_ff @(posedge clock) begin
      if (rd_req.en) begin
         for (int i = 0; i < BYTES_PER_WORD; i++) begin
            rd_data_ff[i*BYTE_W +: BYTE_W] <= line_mem_ff[rd_req.word][i];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/clal_ctrl.sv
// Byte parser, discard tracking and line flush sequencer.
module clal_ctrl
   import clal_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   clal_req_if.sink          req_bus,
   clal_rsp_if.source        rsp_bus,
   output ram_wr_type        wr_req,
   output ram_rd_type        rd_req,
   input  logic [WORD_W-1:0] rd_data
);

   state_type          state_ff, state_in;
   mode_type           mode_ff, mode_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic               last_cr_ff, last_cr_in;
   logic [FILL_W-1:0]  rem_ff, rem_in;
   logic [WORD_AW-1:0] word_ff, word_in;

   logic               accept;
   logic               is_cr;
   logic               is_lf;
   logic               full;
   logic               store;
   logic [CNT_W-1:0]   count;
   logic               last;
   logic [WORD_W-1:0]  keep_mask;

   assign is_cr = (req_bus.rx_byte == CH_CR);
   assign is_lf = (req_bus.rx_byte == CH_LF);
   assign full  = (fill_ff >= FILL_W'(LINE_BYTES));

   // Word size and last flag from the bytes still to send
   assign count = (rem_ff >= FILL_W'(BYTES_PER_WORD)) ? CNT_W'(BYTES_PER_WORD)
                                                      : rem_ff[CNT_W-1:0];
   assign last  = (rem_ff <= FILL_W'(BYTES_PER_WORD));

   // Zero the lanes beyond the word's byte count
   always_comb begin
      for (int i = 0; i < BYTES_PER_WORD; i++) begin
         keep_mask[i*BYTE_W +: BYTE_W] = (CNT_W'(i) < count) ? {BYTE_W{1'b1}}
                                                              : {BYTE_W{1'b0}};
      end
   end

   assign rsp_bus.line_bytes = rd_data & keep_mask;
   assign rsp_bus.byte_count = count;
   assign rsp_bus.last_word  = last;

   // Bytes are taken only between flushes, so store writes never overlap reads
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign rsp_bus.valid = (state_ff == ST_OUT);
   assign accept        = req_bus.valid && req_bus.ready;

   // Store write port: next free byte slot
   assign wr_req.en   = store;
   assign wr_req.word = fill_ff[ADDR_W-1:LANE_W];
   assign wr_req.lane = fill_ff[LANE_W-1:0];
   assign wr_req.data = req_bus.rx_byte;

   // Next state and control
   always_comb begin
      state_in   = state_ff;
      mode_in    = mode_ff;
      fill_in    = fill_ff;
      last_cr_in = last_cr_ff;
      rem_in     = rem_ff;
      word_in    = word_ff;
      store      = 1'b0;
      rd_req.en   = 1'b0;
      rd_req.word = word_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (mode_ff)
                  MODE_DISCARD: begin
                     if (is_cr) begin
                        mode_in = MODE_DISCARD_CR;
                     end
                  end
                  MODE_DISCARD_CR: begin
                     if (is_lf) begin
                        fill_in = '0;
                        mode_in = MODE_NORMAL;
                     end else begin
                        mode_in = MODE_DISCARD;
                     end
                  end
                  MODE_NORMAL: begin
                     if (!is_lf && !full) begin
                        store = 1'b1;
                     end else if (fill_ff == '0) begin
                        store = 1'b1;
                     end else if (last_cr_ff) begin
                        // line complete: flush without the trailing CR
                        rem_in   = fill_ff - FILL_W'(1);
                        word_in  = '0;
                        state_in = ST_READ;
                     end else if (!full) begin
                        store = 1'b1;
                     end else begin
                        mode_in = is_cr ? MODE_DISCARD_CR : MODE_DISCARD;
                     end
                  end
                  default: begin
                     mode_in = MODE_NORMAL;
                  end
               endcase
               if (store) begin
                  fill_in    = fill_ff + FILL_W'(1);
                  last_cr_in = is_cr;
               end
            end
         end
         ST_READ: begin
            rd_req.en = 1'b1;
            state_in  = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_bus.ready) begin
               if (last) begin
                  fill_in  = '0;
                  state_in = ST_IDLE;
               end else begin
                  rem_in   = rem_ff - FILL_W'(BYTES_PER_WORD);
                  word_in  = word_ff + WORD_AW'(1);
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mode_ff  <= MODE_NORMAL;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         fill_ff  <= fill_in;
      end
   end

   // Flush bookkeeping
   always_ff @(posedge clock) begin
      last_cr_ff <= last_cr_in;
      rem_ff     <= rem_in;
      word_ff    <= word_in;
   end

endmodule

>>> rtl/core/clal_checker.sv
// Port-level checks for the line assembler, bound to the top level.
`include "crlf_line_assembler_core_defines.svh"

module clal_checker
   import clal_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [WORD_W-1:0] rsp_line_bytes,
   input logic [CNT_W-1:0]  rsp_byte_count,
   input logic              rsp_last_word
);

   logic rsp_stall;
   assign rsp_stall = rsp_valid && !rsp_ready;

   // A stalled word holds until taken
   `CLAL_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_line_bytes) && $stable(rsp_byte_count) && $stable(rsp_last_word), "result word changed while stalled")

   // No byte is taken while a line is being flushed
   `CLAL_ASSERT_IMP(a_no_accept_in_flush, clock, reset, rsp_valid, !req_ready, "byte accepted during flush")

   // Only the last word of a line may be short
   `CLAL_ASSERT_IMP(a_full_inner_words, clock, reset, rsp_valid && !rsp_last_word, rsp_byte_count == CNT_W'(BYTES_PER_WORD), "short word before end of line")

   // An empty word is a whole empty line
   `CLAL_ASSERT_IMP(a_empty_line, clock, reset, rsp_valid && (rsp_byte_count == '0), rsp_last_word && (rsp_line_bytes == '0), "bad empty line word")

   // Word never carries more than eight bytes
   `CLAL_ASSERT_IMP(a_count_range, clock, reset, rsp_valid, rsp_byte_count <= CNT_W'(BYTES_PER_WORD), "byte count out of range")

endmodule

bind crlf_line_assembler_core clal_checker u_clal_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_line_bytes (rsp_bus.line_bytes),
   .rsp_byte_count (rsp_bus.byte_count),
   .rsp_last_word  (rsp_bus.last_word)
);

>>> verif/crlf_line_assembler_core_tb.sv
// Self-checking testbench for the CR LF line assembler core.
`timescale 1ns / 1ps

module crlf_line_assembler_core_tb;
   import clal_pkg::*;

   // One packed line word as it should leave the core
   typedef struct {
      logic [WORD_W-1:0] data;
      logic [CNT_W-1:0]  count;
      logic              last_flag;
   } line_word_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   clal_req_if req_bus ();
   clal_rsp_if rsp_bus ();

   crlf_line_assembler_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #2 clock = ~clock;

   // Stimulus and expected line words
   logic [BYTE_W-1:0] rx_byte_q[$];
   line_word_t        line_word_q[$];

   // Shadow copy of the line store and its assembly state
   logic [BYTE_W-1:0] held_bytes[LINE_BYTES];
   int unsigned       held_count = 0;
   mode_type          line_mode = MODE_NORMAL;

   int error_count     = 0;
   int bytes_accepted  = 0;
   int words_checked   = 0;
   int lines_expected  = 0;
   int longest_flush   = 0;
   int discard_entries = 0;
   int cycle_count     = 0;

   // Window with no idling on either side
   wire steady = (cycle_count >= 600) && (cycle_count < 1800);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t ns: %s", $time, what);
      error_count++;
   endtask

   // Store one byte in the shadow line store
   task automatic hold_byte(input logic [BYTE_W-1:0] ch);
      held_bytes[held_count] = ch;
      held_count++;
   endtask

   // Full store with no CR to flush on: drop the byte and start discarding
   task automatic enter_discard(input logic [BYTE_W-1:0] ch);
      line_mode = (ch == CH_CR) ? MODE_DISCARD_CR : MODE_DISCARD;
      discard_entries++;
   endtask

   // Advance the shadow state by one accepted byte, queue any line words
   task automatic absorb_byte(input logic [BYTE_W-1:0] ch);
      bit          full;
      int unsigned len;
      int unsigned words;
      int unsigned n;
      int unsigned idx;
      line_word_t  w;
      if (line_mode == MODE_DISCARD) begin
         if (ch == CH_CR) line_mode = MODE_DISCARD_CR;
         return;
      end
      if (line_mode == MODE_DISCARD_CR) begin
         if (ch == CH_LF) begin
            held_count = 0;
            line_mode  = MODE_NORMAL;
         end else begin
            line_mode = MODE_DISCARD;
         end
         return;
      end
      full = (held_count >= LINE_BYTES);
      if (ch != CH_LF && !full) begin
         hold_byte(ch);
         return;
      end
      // a lone LF into an empty store is plain data
      if (held_count == 0) begin
         hold_byte(ch);
         return;
      end
      if (held_bytes[held_count-1] == CH_CR) begin
         // emit the line minus its CR, eight bytes per word, low lane first
         len   = held_count - 1;
         words = (len == 0) ? 1 : (len + 7) / 8;
         for (int unsigned wi = 0; wi < words; wi++) begin
            w.data = '0;
            n      = 0;
            for (int unsigned i = 0; i < BYTES_PER_WORD; i++) begin
               idx = wi * BYTES_PER_WORD + i;
               if (idx < len) begin
                  w.data[BYTE_W*i +: BYTE_W] = held_bytes[idx];
                  n++;
               end
            end
            w.count     = CNT_W'(n);
            w.last_flag = (wi == words - 1);
            line_word_q.push_back(w);
         end
         lines_expected++;
         if (words > longest_flush) longest_flush = words;
         held_count = 0;
         line_mode  = MODE_NORMAL;
         return;
      end
      if (!full) hold_byte(ch);
      else enter_discard(ch);
   endtask

   // Byte driver: pops the pending queue, idles at random
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid   <= 1'b0;
         req_bus.rx_byte <= '0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            absorb_byte(req_bus.rx_byte);
            bytes_accepted++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (rx_byte_q.size() != 0 && (steady || $urandom_range(0, 99) >= 28)) begin
               req_bus.valid   <= 1'b1;
               req_bus.rx_byte <= rx_byte_q.pop_front();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Word monitor: compares each transaction with the oldest expected word
   always @(posedge clock) begin : word_monitor
      line_word_t want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (line_word_q.size() == 0) begin
               report_mismatch($sformatf("unexpected word data=%h count=%0d last=%0b",
                                         rsp_bus.line_bytes, rsp_bus.byte_count,
                                         rsp_bus.last_word));
            end else begin
               want = line_word_q.pop_front();
               if (rsp_bus.line_bytes !== want.data)
                  report_mismatch($sformatf("word %0d line_bytes %h, want %h",
                                            words_checked, rsp_bus.line_bytes, want.data));
               if (rsp_bus.byte_count !== want.count)
                  report_mismatch($sformatf("word %0d byte_count %0d, want %0d",
                                            words_checked, rsp_bus.byte_count, want.count));
               if (rsp_bus.last_word !== want.last_flag)
                  report_mismatch($sformatf("word %0d last_word %0b, want %0b",
                                            words_checked, rsp_bus.last_word,
                                            want.last_flag));
            end
            words_checked++;
         end
         rsp_bus.ready <= steady || ($urandom_range(0, 99) >= 28);
      end
   end

   task automatic send_byte(input logic [BYTE_W-1:0] b);
      rx_byte_q.push_back(b);
   endtask

   // Random line content: never CR, LF only when allowed (and then now and then)
   function automatic logic [BYTE_W-1:0] rand_text_byte(input bit allow_lf);
      logic [BYTE_W-1:0] b;
      b = BYTE_W'($urandom_range(0, 255));
      if (b == CH_CR || (!allow_lf && b == CH_LF)) b = 8'h5A;
      if (allow_lf && $urandom_range(0, 15) == 0) b = CH_LF;
      return b;
   endfunction

   // Byte that lands on a full store
   function automatic logic [BYTE_W-1:0] rand_trigger_byte();
      case ($urandom_range(0, 2))
         0:       return CH_CR;
         1:       return CH_LF;
         default: return BYTE_W'($urandom_range(0, 255));
      endcase
   endfunction

   // Block until the sender is empty and every expected word has come back
   task automatic wait_drained();
      int guard;
      guard = 0;
      while ((rx_byte_q.size() != 0 || req_bus.valid || line_word_q.size() != 0)
             && guard < 20000) begin
         @(negedge clock);
         guard++;
      end
      if (line_word_q.size() != 0) begin
         report_mismatch($sformatf("%0d expected line words never arrived",
                                   line_word_q.size()));
         line_word_q.delete();
      end
   endtask

   // Fill the store to the brim; kind 0 ends it on CR, kind 1 forces discard mode
   task automatic overfill_line(input int kind);
      if (kind == 0) begin
         repeat (LINE_BYTES - 1) send_byte(rand_text_byte(1'b1));
         send_byte(CH_CR);
         send_byte(rand_trigger_byte());
      end else begin
         repeat (LINE_BYTES) send_byte(rand_text_byte(1'b1));
         send_byte(rand_trigger_byte());
         repeat ($urandom_range(1, 4)) send_byte(rand_text_byte(1'b0));
         send_byte(CH_CR);
         send_byte(CH_CR);
         send_byte(rand_text_byte(1'b0));
         send_byte(CH_LF);
         repeat ($urandom_range(0, 3)) send_byte(rand_text_byte(1'b0));
         send_byte(CH_CR);
         send_byte(CH_LF);
      end
   endtask

   initial begin : stimulus
      int short_bytes;
      int n;
      int k;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty line
      send_byte(CH_CR);
      send_byte(CH_LF);
      // LF into an empty store, extreme bytes, LF not after CR
      send_byte(CH_LF);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(CH_LF);
      send_byte(CH_CR);
      send_byte(CH_LF);
      // line holding a single CR
      send_byte(CH_CR);
      send_byte(CH_CR);
      send_byte(CH_LF);
      // exactly one full word
      for (int i = 0; i < 8; i++) send_byte(BYTE_W'(8'h61 + i));
      send_byte(CH_CR);
      send_byte(CH_LF);
      wait_drained();

      // Random: mostly well-formed lines, some noise, two overfilled lines
      short_bytes = 0;
      k = 0;
      while (short_bytes < 160 || k < 12) begin
         if (k == 2) overfill_line(0);
         else if (k == 5) overfill_line(1);
         if (k == 6) wait_drained();
         if ($urandom_range(0, 99) < 80) begin
            n = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 10) : $urandom_range(11, 60);
            repeat (n) send_byte(rand_text_byte(1'b1));
            if ($urandom_range(0, 5) == 0) begin
               send_byte(CH_CR);
               n++;
            end
            send_byte(CH_CR);
            send_byte(CH_LF);
            short_bytes += n + 2;
         end else begin
            n = $urandom_range(1, 6);
            repeat (n) begin
               case ($urandom_range(0, 3))
                  0:       send_byte(CH_CR);
                  1:       send_byte(CH_LF);
                  2:       send_byte(BYTE_W'($urandom_range(0, 255)));
                  default: send_byte(rand_text_byte(1'b1));
               endcase
            end
            short_bytes += n;
         end
         k++;
      end

      wait_drained();
      // let any stray word surface
      repeat (80) @(negedge clock);

      $display("Covered %0d bytes and %0d line words over %0d emitted lines.",
               bytes_accepted, words_checked, lines_expected);
      $display("Longest flush was %0d words; discard mode entered %0d times.",
               longest_flush, discard_entries);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #(4 * 400000);
      $display("DONE: errors detected");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/clal_pkg.sv
rtl/core/clal_req_if.sv
rtl/core/clal_rsp_if.sv
rtl/core/clal_line_ram.sv
rtl/core/clal_ctrl.sv
rtl/core/crlf_line_assembler_core.sv
rtl/core/clal_checker.sv
verif/crlf_line_assembler_core_tb.sv
